// ----- src/rmq_pkg.sv -----
// Package with widths, types and constants shared by the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// Trace and square-root argument: sum of three elements plus one.
	localparam int SUM_W   = DATA_WIDTH + 2;
	localparam int ARG_W   = SUM_W - 1;
	// Radicand is the argument scaled by the fraction bits, padded to an even width.
	localparam int RAD_W   = ARG_W + FRAC_BITS;
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int SQ_IN_W = 2 * ROOT_W;
	// Off-diagonal sums and differences.
	localparam int DIFF_W  = DATA_WIDTH + 1;
	localparam int MAG_W   = DIFF_W;
	// Divider: denominator is 2r, numerator is |d| scaled plus r.
	localparam int DEN_W   = ROOT_W + 1;
	localparam int NUM_W   = MAG_W + FRAC_BITS;
	localparam int QBITS   = DATA_WIDTH + 1;

	localparam int ONE     = 1 << FRAC_BITS;
	localparam int MAXPOS  = (1 << (DATA_WIDTH - 1)) - 1;
	localparam int LATENCY = 3 + ROOT_W + QBITS;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} lane_t;

	typedef struct packed {
		branch_t         br;
		logic            degen;
		lane_t [2:0]     lane;
	} sq_side_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [DEN_W-1:0] rem;
		logic [QBITS-1:0] num;
		logic [QBITS-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		branch_t           br;
		logic              degen;
		logic [ROOT_W-1:0] big;
		logic [DEN_W-1:0]  den;
	} div_side_t;

endpackage
`default_nettype wire

// ----- src/rmq_front.sv -----
// Input stage: trace, branch choice, square-root argument and off-diagonal terms.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m00,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m01,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m02,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m10,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m11,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m12,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m20,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m21,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m22,
	output logic                                       valid_q,
	output logic [rmq_pkg::SQ_IN_W-1:0]                rad_q,
	output rmq_pkg::sq_side_t                          side_q
);

	function automatic rmq_pkg::lane_t make_lane(
		input logic signed [rmq_pkg::DATA_WIDTH-1:0] a,
		input logic signed [rmq_pkg::DATA_WIDTH-1:0] b,
		input logic                                  sub
	);
		logic signed [rmq_pkg::DIFF_W-1:0] d;
		rmq_pkg::lane_t                    l;
		d = sub ? (rmq_pkg::DIFF_W'(a) - rmq_pkg::DIFF_W'(b))
		        : (rmq_pkg::DIFF_W'(a) + rmq_pkg::DIFF_W'(b));
		l.neg = d[rmq_pkg::DIFF_W-1];
		l.mag = l.neg ? rmq_pkg::MAG_W'(-d) : rmq_pkg::MAG_W'(d);
		return l;
	endfunction

	logic signed [rmq_pkg::SUM_W-1:0] a00, a11, a22, one_s, trace, arg;
	logic [rmq_pkg::ARG_W-1:0]        arg_u;
	rmq_pkg::sq_side_t                side_d;

	always_comb begin
		a00   = rmq_pkg::SUM_W'(m00);
		a11   = rmq_pkg::SUM_W'(m11);
		a22   = rmq_pkg::SUM_W'(m22);
		one_s = rmq_pkg::SUM_W'(rmq_pkg::ONE);
		trace = a00 + a11 + a22;
		side_d.degen = 1'b0;
		if (trace > 0) begin
			side_d.br      = rmq_pkg::BR_TRACE;
			arg            = trace + one_s;
			side_d.lane[0] = make_lane(m21, m12, 1'b1);
			side_d.lane[1] = make_lane(m02, m20, 1'b1);
			side_d.lane[2] = make_lane(m10, m01, 1'b1);
		end else if (m00 > m11 && m00 > m22) begin
			side_d.br      = rmq_pkg::BR_X;
			arg            = one_s + a00 - a11 - a22;
			side_d.lane[0] = make_lane(m21, m12, 1'b1);
			side_d.lane[1] = make_lane(m01, m10, 1'b0);
			side_d.lane[2] = make_lane(m02, m20, 1'b0);
		end else if (m11 > m22) begin
			side_d.br      = rmq_pkg::BR_Y;
			arg            = one_s + a11 - a00 - a22;
			side_d.lane[0] = make_lane(m02, m20, 1'b1);
			side_d.lane[1] = make_lane(m01, m10, 1'b0);
			side_d.lane[2] = make_lane(m12, m21, 1'b0);
		end else begin
			side_d.br      = rmq_pkg::BR_Z;
			arg            = one_s + a22 - a00 - a11;
			side_d.lane[0] = make_lane(m10, m01, 1'b1);
			side_d.lane[1] = make_lane(m02, m20, 1'b0);
			side_d.lane[2] = make_lane(m12, m21, 1'b0);
		end
		// An argument at or below zero is clamped to one LSB.
		if (arg <= 0) begin
			side_d.degen = 1'b1;
			arg          = rmq_pkg::SUM_W'(1);
		end
		arg_u = arg[rmq_pkg::ARG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= rmq_pkg::SQ_IN_W'(arg_u) << rmq_pkg::FRAC_BITS;
		side_q <= side_d;
	end

endmodule
`default_nettype wire

// ----- src/rmq_sqrt_cell.sv -----
// One cell of the square-root chain: resolves one root bit from two radicand bits.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid,
	input  wire logic [rmq_pkg::SQ_IN_W-1:0]  rad,
	input  wire logic [rmq_pkg::ROOT_W:0]     rem,
	input  wire logic [rmq_pkg::ROOT_W-1:0]   root,
	input  wire rmq_pkg::sq_side_t            side,
	output logic                              valid_q,
	output logic [rmq_pkg::SQ_IN_W-1:0]       rad_q,
	output logic [rmq_pkg::ROOT_W:0]          rem_q,
	output logic [rmq_pkg::ROOT_W-1:0]        root_q,
	output rmq_pkg::sq_side_t                 side_q
);

	logic [rmq_pkg::ROOT_W+2:0] t, trial, diff;
	logic                       ge;

	always_comb begin
		t     = {rem, rad[rmq_pkg::SQ_IN_W-1 -: 2]};
		trial = {1'b0, root, 2'b01};
		diff  = t - trial;
		ge    = (t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= rad << 2;
		rem_q  <= ge ? diff[rmq_pkg::ROOT_W:0] : t[rmq_pkg::ROOT_W:0];
		root_q <= {root[rmq_pkg::ROOT_W-2:0], ge};
		side_q <= side;
	end

endmodule
`default_nettype wire

// ----- src/rmq_div_cell.sv -----
// One cell of the divider chain: one quotient bit for each of the three lanes.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid,
	input  wire rmq_pkg::div_side_t     side,
	input  wire rmq_pkg::div_lane_t [2:0] lanes,
	output logic                        valid_q,
	output rmq_pkg::div_side_t          side_q,
	output rmq_pkg::div_lane_t [2:0]    lanes_q
);

	rmq_pkg::div_lane_t [2:0]   nxt;
	logic [rmq_pkg::DEN_W:0]    t, diff;
	logic                       ge;

	always_comb begin
		nxt  = lanes;
		t    = '0;
		diff = '0;
		ge   = 1'b0;
		for (int j = 0; j < 3; j++) begin
			t    = {lanes[j].rem, lanes[j].num[rmq_pkg::QBITS-1]};
			diff = t - {1'b0, side.den};
			ge   = (t >= {1'b0, side.den});
			nxt[j].rem = ge ? diff[rmq_pkg::DEN_W-1:0] : t[rmq_pkg::DEN_W-1:0];
			nxt[j].num = lanes[j].num << 1;
			nxt[j].quo = {lanes[j].quo[rmq_pkg::QBITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q  <= side;
		lanes_q <= nxt;
	end

endmodule
`default_nettype wire

// ----- src/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix in, unit quaternion out, through a chain of pipeline cells.
//
// Usage. A matrix is transferred in at a rising edge where start is high and busy is
// low. busy is held low: the pipeline takes a new matrix on every clock cycle, with no
// gaps needed between transfers. Each matrix gives exactly one result, presented on
// qw, qx, qy, qz, branch_taken and degenerate for a single cycle while done is high;
// that result transfer completes at the edge ending the cycle.
// An accepted matrix passes through one input stage, one square-root cell per root bit,
// one divider set-up stage, one divider cell per quotient bit and one output register.
// Throughput is one matrix per cycle; each cell hands its item on every clock.
// The receiver cannot stall the block, so results are never held back or dropped.
// Reset clears every valid bit in the chain, so items in flight are discarded and no
// result appears until a new matrix has gone the whole way through.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m00,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m01,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m02,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m10,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m11,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m12,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m20,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m21,
	input  wire logic signed [rmq_pkg::DATA_WIDTH-1:0] m22,
	output logic                                       done,
	output logic signed [rmq_pkg::DATA_WIDTH-1:0]      qw,
	output logic signed [rmq_pkg::DATA_WIDTH-1:0]      qx,
	output logic signed [rmq_pkg::DATA_WIDTH-1:0]      qy,
	output logic signed [rmq_pkg::DATA_WIDTH-1:0]      qz,
	output logic [1:0]                                 branch_taken,
	output logic                                       degenerate
);

	localparam int SQ_N  = rmq_pkg::ROOT_W;
	localparam int DIV_N = rmq_pkg::QBITS;
	localparam int DW    = rmq_pkg::DATA_WIDTH;

	// The chain never back-pressures its source.
	assign busy = 1'b0;

	// Square-root chain. Index 0 is the input stage; index k is after k root bits.
	logic                          sq_valid [0:SQ_N];
	logic [rmq_pkg::SQ_IN_W-1:0]   sq_rad   [0:SQ_N];
	logic [rmq_pkg::ROOT_W:0]      sq_rem   [0:SQ_N];
	logic [rmq_pkg::ROOT_W-1:0]    sq_root  [0:SQ_N];
	rmq_pkg::sq_side_t             sq_side  [0:SQ_N];

	rmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.m00      (m00),
		.m01      (m01),
		.m02      (m02),
		.m10      (m10),
		.m11      (m11),
		.m12      (m12),
		.m20      (m20),
		.m21      (m21),
		.m22      (m22),
		.valid_q  (sq_valid[0]),
		.rad_q    (sq_rad[0]),
		.side_q   (sq_side[0])
	);

	// The partial remainder and root start from zero for each item.
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		rmq_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid   (sq_valid[k]),
			.rad     (sq_rad[k]),
			.rem     (sq_rem[k]),
			.root    (sq_root[k]),
			.side    (sq_side[k]),
			.valid_q (sq_valid[k+1]),
			.rad_q   (sq_rad[k+1]),
			.rem_q   (sq_rem[k+1]),
			.root_q  (sq_root[k+1]),
			.side_q  (sq_side[k+1])
		);
	end

	// Divider set-up: the denominator is 2r, the numerator |d| scaled plus r, so that
	// the truncating quotient gives the rounded result. A quotient too wide for the
	// chain is flagged here and saturated at the output.
	logic [rmq_pkg::ROOT_W-1:0]     r_val;
	logic [rmq_pkg::ROOT_W:0]       r_inc;
	logic [rmq_pkg::NUM_W-1:0]      num_full [3];
	rmq_pkg::div_side_t             setup_side;
	rmq_pkg::div_lane_t [2:0]       setup_lanes;

	always_comb begin
		r_val = sq_root[SQ_N];
		if (r_val == '0) begin
			r_val = rmq_pkg::ROOT_W'(1);
		end
		r_inc           = {1'b0, r_val} + 1'b1;
		setup_side.br    = sq_side[SQ_N].br;
		setup_side.degen = sq_side[SQ_N].degen;
		setup_side.big   = r_inc[rmq_pkg::ROOT_W:1];
		setup_side.den   = {r_val, 1'b0};
		for (int j = 0; j < 3; j++) begin
			num_full[j] = (rmq_pkg::NUM_W'(sq_side[SQ_N].lane[j].mag) << rmq_pkg::FRAC_BITS)
			            + rmq_pkg::NUM_W'(r_val);
			setup_lanes[j].neg = sq_side[SQ_N].lane[j].neg;
			setup_lanes[j].ovf =
				(rmq_pkg::DEN_W'(num_full[j][rmq_pkg::NUM_W-1:rmq_pkg::QBITS]) >= setup_side.den);
			setup_lanes[j].rem = rmq_pkg::DEN_W'(num_full[j][rmq_pkg::NUM_W-1:rmq_pkg::QBITS]);
			setup_lanes[j].num = num_full[j][rmq_pkg::QBITS-1:0];
			setup_lanes[j].quo = '0;
		end
	end

	logic                       dv_valid [0:DIV_N];
	rmq_pkg::div_side_t         dv_side  [0:DIV_N];
	rmq_pkg::div_lane_t [2:0]   dv_lanes [0:DIV_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid[0] <= 1'b0;
		end else begin
			dv_valid[0] <= sq_valid[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		dv_side[0]  <= setup_side;
		dv_lanes[0] <= setup_lanes;
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		rmq_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid   (dv_valid[k]),
			.side    (dv_side[k]),
			.lanes   (dv_lanes[k]),
			.valid_q (dv_valid[k+1]),
			.side_q  (dv_side[k+1]),
			.lanes_q (dv_lanes[k+1])
		);
	end

	// Output stage: signed saturation of each small component, then placement of
	// the large component in the slot given by the branch.
	logic [DW-1:0]              lane_v [3];
	logic [rmq_pkg::QBITS-1:0]  q_neg;
	logic [DW-1:0]              big_v;
	logic [DW-1:0]              comp_d [4];
	rmq_pkg::div_side_t         fin_side;
	rmq_pkg::div_lane_t [2:0]   fin_lanes;

	always_comb begin
		fin_side  = dv_side[DIV_N];
		fin_lanes = dv_lanes[DIV_N];
		q_neg     = '0;
		for (int j = 0; j < 3; j++) begin
			q_neg = rmq_pkg::QBITS'(0) - fin_lanes[j].quo;
			if (!fin_lanes[j].neg) begin
				if (fin_lanes[j].ovf || fin_lanes[j].quo > rmq_pkg::QBITS'(rmq_pkg::MAXPOS)) begin
					lane_v[j] = DW'(rmq_pkg::MAXPOS);
				end else begin
					lane_v[j] = fin_lanes[j].quo[DW-1:0];
				end
			end else begin
				if (fin_lanes[j].ovf
				    || fin_lanes[j].quo > rmq_pkg::QBITS'(rmq_pkg::MAXPOS + 1)) begin
					lane_v[j] = {1'b1, {(DW-1){1'b0}}};
				end else begin
					lane_v[j] = q_neg[DW-1:0];
				end
			end
		end
		if (rmq_pkg::DEN_W'(fin_side.big) > rmq_pkg::DEN_W'(rmq_pkg::MAXPOS)) begin
			big_v = DW'(rmq_pkg::MAXPOS);
		end else begin
			big_v = DW'(fin_side.big);
		end
		case (fin_side.br)
			rmq_pkg::BR_TRACE: begin
				comp_d[0] = big_v;     comp_d[1] = lane_v[0];
				comp_d[2] = lane_v[1]; comp_d[3] = lane_v[2];
			end
			rmq_pkg::BR_X: begin
				comp_d[0] = lane_v[0]; comp_d[1] = big_v;
				comp_d[2] = lane_v[1]; comp_d[3] = lane_v[2];
			end
			rmq_pkg::BR_Y: begin
				comp_d[0] = lane_v[0]; comp_d[1] = lane_v[1];
				comp_d[2] = big_v;     comp_d[3] = lane_v[2];
			end
			default: begin
				comp_d[0] = lane_v[0]; comp_d[1] = lane_v[1];
				comp_d[2] = lane_v[2]; comp_d[3] = big_v;
			end
		endcase
	end

	logic          done_q;
	logic [DW-1:0] qw_q, qx_q, qy_q, qz_q;
	logic [1:0]    br_q;
	logic          degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		qw_q    <= comp_d[0];
		qx_q    <= comp_d[1];
		qy_q    <= comp_d[2];
		qz_q    <= comp_d[3];
		br_q    <= fin_side.br;
		degen_q <= fin_side.degen;
	end

	assign done         = done_q;
	assign qw           = qw_q;
	assign qx           = qx_q;
	assign qy           = qy_q;
	assign qz           = qz_q;
	assign branch_taken = br_q;
	assign degenerate   = degen_q;

`ifndef SYNTH
	// Every accepted matrix comes out with done high once it has passed the whole chain.
	a_latency_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rmq_pkg::LATENCY) done)
		else $error("result missing after pipeline latency");

	// No result appears without a matrix accepted at the matching earlier edge.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, rmq_pkg::LATENCY))
		else $error("result without a matching input transfer");

	// A positive trace always yields a positive argument, so it is never clamped.
	a_degen_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (branch_taken != rmq_pkg::BR_TRACE))
		else $error("clamped argument reported on the positive-trace branch");

	// The scalar part on the positive-trace branch is the non-negative half root.
	a_w_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && branch_taken == rmq_pkg::BR_TRACE) |-> !qw[DW-1])
		else $error("negative scalar part on the positive-trace branch");
`endif

endmodule
`default_nettype wire
